FILE: rtl/bsr_pkg.sv
// Shared constants for the record sorter.
// No dependencies; used by the top level and its sub-blocks.
package bsr_pkg;

  // Default store depth and field widths
  localparam int unsigned MAX_RECORDS_DEF = 64;
  localparam int unsigned KEY_BITS_DEF    = 16;
  localparam int unsigned TAG_BITS_DEF    = 8;

endpackage : bsr_pkg

FILE: rtl/bsr_store.sv
// Record store: one write port, one read port with registered read data.
// Depends on bsr_pkg for default sizes.
module bsr_store #(
  parameter int unsigned DEPTH = bsr_pkg::MAX_RECORDS_DEF,
  parameter int unsigned WIDTH = bsr_pkg::KEY_BITS_DEF + bsr_pkg::TAG_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : bsr_store

FILE: rtl/bsr_cmpx.sv
// Compare-exchange unit: decides whether the carried record bubbles past
// the record just read. Depends on bsr_pkg for default sizes.
module bsr_cmpx #(
  parameter int unsigned KEY_BITS = bsr_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS = bsr_pkg::TAG_BITS_DEF
) (
  input  logic                         descending,
  input  logic [TAG_BITS+KEY_BITS-1:0] held_rec,   // earlier position
  input  logic [TAG_BITS+KEY_BITS-1:0] next_rec,   // later position
  output logic                         swap,
  output logic [TAG_BITS+KEY_BITS-1:0] wr_rec,     // goes to earlier slot
  output logic [TAG_BITS+KEY_BITS-1:0] held_nxt    // carried onward
);

  logic [KEY_BITS-1:0] held_key;
  logic [KEY_BITS-1:0] next_key;

  assign held_key = held_rec[KEY_BITS-1:0];
  assign next_key = next_rec[KEY_BITS-1:0];

  // Strict compare keeps equal keys in load order
  assign swap = descending ? (held_key < next_key) : (held_key > next_key);

  // On a swap the later record moves down and the carried one keeps going
  assign wr_rec   = swap ? next_rec : held_rec;
  assign held_nxt = swap ? held_rec : next_rec;

endmodule : bsr_cmpx

FILE: rtl/bubble_sort_records_by_key.sv
// Records are loaded one word per cycle; a word with in_last_record high closes
// the set. Up to MAX_RECORDS records are kept; further words of the set are
// dropped and every result of that set shows out_overflowed. The held records
// are then bubble-sorted in place by one compare-exchange unit that walks the
// store through a single read and a single write port: a priming read of
// slot 0 comes before the first pass, and passes repeat until one pass makes
// no swap. Each sorted word is then read from the store and presented, and
// is held while out_stall is high. Input is stalled from the closing word
// until the final result is taken. Equal keys keep their load order;
// cfg_wdata selects descending order when 1 and must be written only while
// the block is idle; the block itself does not enforce this.
module bubble_sort_records_by_key #(
  parameter int unsigned MAX_RECORDS = bsr_pkg::MAX_RECORDS_DEF,
  parameter int unsigned KEY_BITS    = bsr_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS    = bsr_pkg::TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  // input words
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [TAG_BITS-1:0] in_record_tag,
  input  logic [KEY_BITS-1:0] in_stock_key,
  input  logic                in_last_record,
  // result words
  output logic                out_valid,
  input  logic                out_stall,
  output logic [TAG_BITS-1:0] out_sorted_tag,
  output logic [KEY_BITS-1:0] out_sorted_key,
  output logic                out_last_result,
  output logic                out_overflowed
);

  localparam int unsigned REC_W = TAG_BITS + KEY_BITS;
  localparam int unsigned IDX_W = $clog2(MAX_RECORDS);
  localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);

  typedef enum logic [2:0] {
    ST_LOAD,   // taking input words
    ST_PRIME,  // read slot 0 ahead of the first pass
    ST_HEAD,   // slot 0 arrives, becomes the carried record
    ST_SCAN,   // compare-exchange at slot idx
    ST_TAIL,   // carried record lands in the last slot
    ST_ORD,    // read the next result slot
    ST_OSHOW   // present a result word
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] idx_r;
  logic [REC_W-1:0] held_r;
  logic             swapped_r;
  logic             ovf_r;
  logic             desc_r;

  logic             in_acc;
  logic             out_acc;
  logic             store_full;
  logic             at_last;
  logic [IDX_W-1:0] last_idx;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [REC_W-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [REC_W-1:0] rd_data;

  logic             cx_swap;
  logic [REC_W-1:0] cx_wr_rec;
  logic [REC_W-1:0] cx_held_nxt;

  // Handshakes
  assign in_stall  = (state_r != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OSHOW);
  assign out_acc   = out_valid && !out_stall;

  assign store_full = (count_r == CNT_W'(MAX_RECORDS));
  assign last_idx   = IDX_W'(count_r - CNT_W'(1));
  assign at_last    = (idx_r == last_idx);

  // Store port steering
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = cx_wr_rec;
    rd_en   = 1'b0;
    rd_addr = idx_r;
    unique case (state_r)
      ST_LOAD: begin
        wr_en   = in_acc && !store_full;
        wr_addr = IDX_W'(count_r);
        wr_data = {in_record_tag, in_stock_key};
      end
      ST_PRIME: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      ST_HEAD: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(1);
      end
      ST_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = idx_r - IDX_W'(1);
        wr_data = cx_wr_rec;
        rd_en   = !at_last;
        rd_addr = idx_r + IDX_W'(1);
      end
      ST_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = last_idx;
        wr_data = held_r;
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      ST_ORD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r;
      end
      ST_OSHOW: begin
        rd_en   = 1'b0;
      end
      default: begin
        rd_en   = 1'b0;
      end
    endcase
  end

  bsr_store #(
    .DEPTH (MAX_RECORDS),
    .WIDTH (REC_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bsr_cmpx #(
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_cmpx (
    .descending (desc_r),
    .held_rec   (held_r),
    .next_rec   (rd_data),
    .swap       (cx_swap),
    .wr_rec     (cx_wr_rec),
    .held_nxt   (cx_held_nxt)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      idx_r     <= '0;
      swapped_r <= 1'b0;
      ovf_r     <= 1'b0;
      desc_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        desc_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (store_full) begin
              ovf_r <= 1'b1;
            end else begin
              count_r <= count_r + CNT_W'(1);
            end
            if (in_last_record) begin
              // a set of one needs no sorting
              idx_r   <= '0;
              state_r <= (count_r != '0) ? ST_PRIME : ST_ORD;
            end
          end
        end
        ST_PRIME: begin
          swapped_r <= 1'b0;
          state_r   <= ST_HEAD;
        end
        ST_HEAD: begin
          held_r  <= rd_data;
          idx_r   <= IDX_W'(1);
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          held_r <= cx_held_nxt;
          if (cx_swap) begin
            swapped_r <= 1'b1;
          end
          if (at_last) begin
            state_r <= ST_TAIL;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        ST_TAIL: begin
          // another pass while anything moved
          swapped_r <= 1'b0;
          if (swapped_r) begin
            state_r <= ST_HEAD;
          end else begin
            idx_r   <= '0;
            state_r <= ST_ORD;
          end
        end
        ST_ORD: begin
          state_r <= ST_OSHOW;
        end
        ST_OSHOW: begin
          if (out_acc) begin
            if (at_last) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= ST_LOAD;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= ST_ORD;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  // Result word fields
  assign out_sorted_tag  = rd_data[REC_W-1:KEY_BITS];
  assign out_sorted_key  = rd_data[KEY_BITS-1:0];
  assign out_last_result = at_last;
  assign out_overflowed  = ovf_r;

endmodule : bubble_sort_records_by_key

FILE: tb/sv/bsr_checker.sv
// Scoreboard for the record sorter: watches config, input and result words,
// predicts each sorted run and compares it word by word. Depends on bsr_pkg.
module bsr_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [bsr_pkg::TAG_BITS_DEF-1:0] in_record_tag,
  input  logic [bsr_pkg::KEY_BITS_DEF-1:0] in_stock_key,
  input  logic                             in_last_record,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [bsr_pkg::TAG_BITS_DEF-1:0] out_sorted_tag,
  input  logic [bsr_pkg::KEY_BITS_DEF-1:0] out_sorted_key,
  input  logic                             out_last_result,
  input  logic                             out_overflowed,
  output int                               fail_count,
  output int                               pending_words,
  output int                               checked_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TAG_W = bsr_pkg::TAG_BITS_DEF;
  localparam int unsigned KEY_W = bsr_pkg::KEY_BITS_DEF;
  localparam int unsigned DEPTH = bsr_pkg::MAX_RECORDS_DEF;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] key;
    logic             is_last;
    logic             ovf;
  } sorted_word_t;

  // predicted block state
  logic [KEY_W-1:0] held_key [DEPTH];
  logic [TAG_W-1:0] held_tag [DEPTH];
  int               held_n;
  bit               dropped;
  bit               descending;
  sorted_word_t     expected_words [$];

  // stable bubble sort of the held records; equal keys never swap
  task automatic sort_held();
    bit               moved;
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    if (held_n < 2) return;
    do begin
      moved = 1'b0;
      for (int i = 0; i + 1 < held_n; i++) begin
        if (descending ? (held_key[i] < held_key[i+1]) : (held_key[i] > held_key[i+1])) begin
          k = held_key[i];  held_key[i] = held_key[i+1];  held_key[i+1] = k;
          t = held_tag[i];  held_tag[i] = held_tag[i+1];  held_tag[i+1] = t;
          moved = 1'b1;
        end
      end
    end while (moved);
  endtask

  // load one record; a closing word sorts and queues the whole run
  task automatic take_record();
    sorted_word_t w;
    if (held_n < DEPTH) begin
      held_key[held_n] = in_stock_key;
      held_tag[held_n] = in_record_tag;
      held_n++;
    end else begin
      dropped = 1'b1;
    end
    if (!in_last_record) return;
    sort_held();
    for (int i = 0; i < held_n; i++) begin
      w.tag     = held_tag[i];
      w.key     = held_key[i];
      w.is_last = (i + 1 == held_n);
      w.ovf     = dropped;
      expected_words.push_back(w);
    end
    held_n  = 0;
    dropped = 1'b0;
  endtask

  // compare one result word with the oldest prediction
  task automatic check_word();
    sorted_word_t w;
    if (expected_words.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected result word tag %0d key %0d last %0b ovf %0b", $realtime,
                 out_sorted_tag, out_sorted_key, out_last_result, out_overflowed);
      return;
    end
    w = expected_words.pop_front();
    checked_words++;
    if (out_sorted_tag !== w.tag || out_sorted_key !== w.key ||
        out_last_result !== w.is_last || out_overflowed !== w.ovf) begin
      fail_count++;
      if (fail_count <= 10)
        $display({"%0t: mismatch exp tag %0d key %0d last %0b ovf %0b,",
                  " got tag %0d key %0d last %0b ovf %0b"},
                 $realtime, w.tag, w.key, w.is_last, w.ovf,
                 out_sorted_tag, out_sorted_key, out_last_result, out_overflowed);
    end
  endtask

  // everything is sampled at the edge, before the block updates
  always @(posedge clk) begin
    if (!rst_n) begin
      held_n        = 0;
      dropped       = 1'b0;
      descending    = 1'b0;
      fail_count    = 0;
      checked_words = 0;
      expected_words.delete();
    end else begin
      if (cfg_we) descending = cfg_wdata;
      if (in_valid && !in_stall) take_record();
      if (out_valid && !out_stall) check_word();
    end
    pending_words <= expected_words.size();
  end

endmodule : bsr_checker

FILE: tb/sv/tb.sv
// Top of the record sorter testbench: clock, reset, stimulus and verdict.
// Depends on bsr_pkg, bubble_sort_records_by_key and bsr_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE = 8;
  localparam int TAG_W  = bsr_pkg::TAG_BITS_DEF;
  localparam int KEY_W  = bsr_pkg::KEY_BITS_DEF;
  localparam int DEPTH  = bsr_pkg::MAX_RECORDS_DEF;

  typedef enum int {KEYS_FULL, KEYS_CLUSTERED, KEYS_EDGE} key_mix_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  logic [TAG_W-1:0] in_record_tag;
  logic [KEY_W-1:0] in_stock_key;
  logic             in_last_record;
  logic             out_valid;
  logic             out_stall;
  logic [TAG_W-1:0] out_sorted_tag;
  logic [KEY_W-1:0] out_sorted_key;
  logic             out_last_result;
  logic             out_overflowed;

  int fail_count;
  int pending_words;
  int checked_words;

  // idling control shared by both sides
  bit quiet;
  int idle_pct;
  int words_sent;
  int sets_sent;
  int overflow_sets;

  bubble_sort_records_by_key i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_record_tag  (in_record_tag),
    .in_stock_key   (in_stock_key),
    .in_last_record (in_last_record),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sorted_tag (out_sorted_tag),
    .out_sorted_key (out_sorted_key),
    .out_last_result(out_last_result),
    .out_overflowed (out_overflowed)
  );

  bsr_checker i_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_record_tag  (in_record_tag),
    .in_stock_key   (in_stock_key),
    .in_last_record (in_last_record),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sorted_tag (out_sorted_tag),
    .out_sorted_key (out_sorted_key),
    .out_last_result(out_last_result),
    .out_overflowed (out_overflowed),
    .fail_count     (fail_count),
    .pending_words  (pending_words),
    .checked_words  (checked_words)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #(2_000_000);
    $display("bubble_sort_records_by_key test failed");
    $finish;
  end

  // receiver: random stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [KEY_W-1:0] pick_key(key_mix_t mix);
    unique case (mix)
      KEYS_FULL:      return KEY_W'($urandom);
      KEYS_CLUSTERED: return KEY_W'($urandom_range(0, 7));
      default: begin
        unique case ($urandom_range(0, 3))
          0:       return '0;
          1:       return KEY_W'(1);
          2:       return '1 - 1'b1;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // one word on the input channel, with an optional gap first
  task automatic send_word(input logic [TAG_W-1:0] tag,
                           input logic [KEY_W-1:0] key, input logic is_last);
    if (!quiet && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_record_tag  <= tag;
    in_stock_key   <= key;
    in_last_record <= is_last;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (is_last) sets_sent++;
  endtask

  task automatic send_set(input int n, input key_mix_t mix);
    for (int i = 0; i < n; i++)
      send_word(TAG_W'($urandom), pick_key(mix), i == n - 1);
    if (n > DEPTH) overflow_sets++;
  endtask

  // hold the sender until every predicted word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_dir(input logic desc);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= desc;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic desc, input int pct, input int budget,
                           input int big_n);
    int start;
    start    = words_sent;
    write_dir(desc);
    idle_pct = pct;
    if (big_n > 0) send_set(big_n, key_mix_t'($urandom_range(0, 2)));
    while (words_sent - start < budget)
      send_set($urandom_range(1, 10), key_mix_t'($urandom_range(0, 2)));
  endtask

  initial begin
    quiet          = 1'b0;
    idle_pct       = 20;
    words_sent     = 0;
    sets_sent      = 0;
    overflow_sets  = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    in_valid       = 1'b0;
    in_record_tag  = '0;
    in_stock_key   = '0;
    in_last_record = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed, ascending: lone records at both extremes, ties, reversed input
    write_dir(1'b0);
    send_word(8'd0, 16'd0, 1'b1);
    send_word(8'd255, 16'hffff, 1'b1);
    send_word(8'd1, 16'hffff, 1'b0);
    send_word(8'd2, 16'd0, 1'b0);
    send_word(8'd3, 16'd7, 1'b0);
    send_word(8'd4, 16'd7, 1'b1);
    send_word(8'd5, 16'd9, 1'b0);
    send_word(8'd6, 16'd5, 1'b0);
    send_word(8'd7, 16'd1, 1'b1);

    // directed, descending: ties around extremes, lone record, reversed input
    write_dir(1'b1);
    send_word(8'd10, 16'd3, 1'b0);
    send_word(8'd11, 16'd3, 1'b0);
    send_word(8'd12, 16'hffff, 1'b0);
    send_word(8'd13, 16'd0, 1'b0);
    send_word(8'd14, 16'd3, 1'b1);
    send_word(8'd170, 16'h5555, 1'b1);
    send_word(8'd20, 16'd42, 1'b0);
    send_word(8'd21, 16'd42, 1'b1);
    send_word(8'd30, 16'd1, 1'b0);
    send_word(8'd31, 16'd2, 1'b0);
    send_word(8'd32, 16'd3, 1'b0);
    send_word(8'd33, 16'd4, 1'b1);

    // random phases; big sets hit a full store, a dropped closing word and overflow
    run_phase(1'b0, 25, 75, DEPTH);
    run_phase(1'b1, 0, 75, 0);
    run_phase(1'b0, 40, 75, DEPTH + 1);
    run_phase(1'b1, 15, 75, 0);
    run_phase(1'b1, 30, 75, DEPTH + 6);
    quiet = 1'b1;
    run_phase(1'b0, 0, 75, 0);

    drain();
    repeat (16) @(posedge clk);
    $display("Sent %0d records in %0d sets (%0d over store depth), both directions;",
             words_sent, sets_sent, overflow_sets);
    $display("checked %0d sorted words, %0d failures.", checked_words, fail_count);
    if (fail_count == 0) begin
      $display("bubble_sort_records_by_key test passed");
    end else begin
      $display("bubble_sort_records_by_key test failed");
    end
    $finish;
  end

endmodule : tb
